// ===== sv/bri_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the beacon remote ID element extractor.
// Used by the walker, the result queue and the top level; no dependencies.
package bri_pkg;

    // Default geometry of the frame and of one message
    localparam int HEADER_BYTES_DEF    = 36;
    localparam int MESSAGE_BYTES_DEF   = 25;
    localparam int MAX_FRAME_BYTES_DEF = 4095;

    // Fixed vendor element layout: three OUI bytes, type byte, count byte
    localparam logic [7:0] VENDOR_HDR_BYTES = 8'd5;

    // Configuration register indexes
    localparam logic [1:0] CFG_VENDOR_TAG  = 2'd0;
    localparam logic [1:0] CFG_OUI_VALUE   = 2'd1;
    localparam logic [1:0] CFG_OUI_TYPE    = 2'd2;
    localparam logic [1:0] CFG_MIN_PAYLOAD = 2'd3;

    // Register reset values
    localparam logic [7:0]  VENDOR_TAG_RST  = 8'hDD;
    localparam logic [23:0] OUI_VALUE_RST   = {8'hFA, 8'h0B, 8'hBC};
    localparam logic [7:0]  OUI_TYPE_RST    = 8'h0D;
    localparam logic [7:0]  MIN_PAYLOAD_RST = 8'd30;

    // Result kinds
    localparam logic KIND_MSG_BYTE  = 1'b0;
    localparam logic KIND_END_FRAME = 1'b1;

    // Depth of the result queue (power of two)
    localparam int RES_DEPTH = 4;

    typedef struct packed {
        logic [7:0]  vendor_tag;
        logic [23:0] oui_value;
        logic [7:0]  oui_type_value;
        logic [7:0]  min_payload_len;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [11:0] frame_length;
        logic        last_byte;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_out;
        logic [4:0]  byte_index;
        logic [7:0]  message_number;
        logic        message_end;
        logic        found_any;
    } result_t;

    // Up to two results come out of one frame byte
    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
    } res_pair_t;

endpackage

// ===== sv/bri_walker.sv =====
`timescale 1ns / 1ps
// Element walker: holds the per-frame parse state and turns one frame byte
// into zero, one or two results. Depends on bri_pkg.
module bri_walker
    import bri_pkg::*;
#(
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int MESSAGE_BYTES   = MESSAGE_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output res_pair_t results
);

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_TAG    = 6'b000010,
        PH_LEN    = 6'b000100,
        PH_BODY   = 6'b001000,
        PH_STOP   = 6'b010000,
        PH_IDLE   = 6'b100000
    } phase_t;

    localparam logic [12:0] HDR_LEN   = 13'(HEADER_BYTES);
    localparam logic [11:0] MAX_LEN   = 12'(MAX_FRAME_BYTES);
    localparam logic [5:0]  MSG_LEN   = 6'(MESSAGE_BYTES);
    // Reciprocal for the divide by message size; exact for 8-bit dividends
    localparam int          RECIP_INT = 65536 / MESSAGE_BYTES + 1;
    localparam logic [24:0] RECIP     = 25'(RECIP_INT);
    localparam phase_t      START_PH  = (HEADER_BYTES == 0) ? PH_TAG : PH_HEADER;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [11:0] pos_reg, pos_next, pos_cur;
    logic [11:0] total_reg, total_next, total_cur;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  off_reg, off_next;
    logic [7:0]  id_reg, id_next;
    logic [7:0]  allowed_reg, allowed_next;
    logic [7:0]  msg_cnt_reg, msg_cnt_next;
    logic [4:0]  byte_cnt_reg, byte_cnt_next;
    logic        match_reg, match_next, match_cur;
    logic        found_reg, found_next, found_cur;

    logic [7:0]  b;
    logic [11:0] flen_sat;
    logic [7:0]  fit_diff;
    logic [24:0] fit_prod;
    logic [7:0]  fit;
    logic [7:0]  want;
    logic        msg_emit;
    logic        msg_last;
    logic        frame_end;
    result_t     msg_res;
    result_t     end_res;

    assign b        = item.data_byte;
    assign flen_sat = (item.frame_length > MAX_LEN) ? MAX_LEN : item.frame_length;

    // Whole messages that fit behind the five fixed payload bytes
    assign fit_diff = len_reg - VENDOR_HDR_BYTES;
    assign fit_prod = 25'(fit_diff) * RECIP;
    assign fit      = fit_prod[23:16];

    always_comb
    begin
        case (off_reg[1:0])
            2'd0:    want = cfg.oui_value[23:16];
            2'd1:    want = cfg.oui_value[15:8];
            default: want = cfg.oui_value[7:0];
        endcase
    end

    always_comb
    begin
        // A first byte restarts the frame before the byte is parsed
        phase_cur = item.first_byte ? START_PH : phase_reg;
        pos_cur   = item.first_byte ? 12'd0 : pos_reg;
        total_cur = item.first_byte ? flen_sat : total_reg;
        match_cur = item.first_byte ? 1'b0 : match_reg;
        found_cur = item.first_byte ? 1'b0 : found_reg;

        phase_next    = phase_cur;
        pos_next      = pos_cur;
        total_next    = total_cur;
        len_next      = len_reg;
        off_next      = off_reg;
        id_next       = id_reg;
        allowed_next  = allowed_reg;
        msg_cnt_next  = msg_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        match_next    = match_cur;
        found_next    = found_cur;
        msg_emit      = 1'b0;
        msg_last      = ({1'b0, byte_cnt_reg} + 6'd1) >= MSG_LEN;

        case (phase_cur)
            PH_HEADER:
            begin
                if ({1'b0, pos_cur} + 13'd1 >= HDR_LEN)
                begin
                    phase_next = PH_TAG;
                end
            end
            PH_TAG:
            begin
                if ({1'b0, pos_cur} + 13'd2 > {1'b0, total_cur})
                begin
                    phase_next = PH_STOP;
                end
                else
                begin
                    id_next    = b;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                len_next = b;
                off_next = 8'd0;
                if ({1'b0, pos_cur} + 13'd1 + 13'(b) > {1'b0, total_cur})
                begin
                    phase_next = PH_STOP;
                end
                else
                begin
                    match_next    = (id_reg == cfg.vendor_tag) &&
                                    (b >= cfg.min_payload_len) &&
                                    (b >= VENDOR_HDR_BYTES);
                    allowed_next  = 8'd0;
                    msg_cnt_next  = 8'd0;
                    byte_cnt_next = 5'd0;
                    phase_next    = (b == 8'd0) ? PH_TAG : PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (match_cur)
                begin
                    if (off_reg < 8'd3)
                    begin
                        if (b != want)
                        begin
                            match_next = 1'b0;
                        end
                    end
                    else if (off_reg == 8'd3)
                    begin
                        if (b != cfg.oui_type_value)
                        begin
                            match_next = 1'b0;
                        end
                    end
                    else if (off_reg == 8'd4)
                    begin
                        allowed_next = (b < fit) ? b : fit;
                        if (allowed_next == 8'd0)
                        begin
                            match_next = 1'b0;
                        end
                    end
                    else if (msg_cnt_reg < allowed_reg)
                    begin
                        msg_emit   = 1'b1;
                        found_next = 1'b1;
                        if (msg_last)
                        begin
                            byte_cnt_next = 5'd0;
                            msg_cnt_next  = msg_cnt_reg + 8'd1;
                        end
                        else
                        begin
                            byte_cnt_next = byte_cnt_reg + 5'd1;
                        end
                    end
                end
                if ({1'b0, off_reg} + 9'd1 >= {1'b0, len_reg})
                begin
                    phase_next = PH_TAG;
                end
                else
                begin
                    off_next = off_reg + 8'd1;
                end
            end
            default:
            begin
            end
        endcase

        frame_end = 1'b0;
        if (phase_cur != PH_IDLE)
        begin
            if (pos_cur < MAX_LEN)
            begin
                pos_next = pos_cur + 12'd1;
            end
            if (item.last_byte || (pos_next >= total_cur))
            begin
                frame_end  = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_comb
    begin
        msg_res                = '0;
        msg_res.kind           = KIND_MSG_BYTE;
        msg_res.data_out       = b;
        msg_res.byte_index     = byte_cnt_reg;
        msg_res.message_number = msg_cnt_reg;
        msg_res.message_end    = msg_last;

        end_res           = '0;
        end_res.kind      = KIND_END_FRAME;
        end_res.found_any = found_next;

        results      = '0;
        results.res0 = msg_emit ? msg_res : end_res;
        results.res1 = end_res;
        results.count = 2'(msg_emit) + 2'(frame_end);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            pos_reg      <= '0;
            total_reg    <= '0;
            len_reg      <= '0;
            off_reg      <= '0;
            id_reg       <= '0;
            allowed_reg  <= '0;
            msg_cnt_reg  <= '0;
            byte_cnt_reg <= '0;
            match_reg    <= 1'b0;
            found_reg    <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            total_reg    <= total_next;
            len_reg      <= len_next;
            off_reg      <= off_next;
            id_reg       <= id_next;
            allowed_reg  <= allowed_next;
            msg_cnt_reg  <= msg_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            match_reg    <= match_next;
            found_reg    <= found_next;
        end
    end

endmodule

// ===== sv/bri_result_fifo.sv =====
`timescale 1ns / 1ps
// Result queue: takes up to two results per cycle, hands out one per cycle.
// Depends on bri_pkg.
module bri_result_fifo
    import bri_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push_en,
    input  res_pair_t push,
    input  logic      pop,
    output result_t   head,
    output logic      not_empty,
    output logic      room2
);

    localparam int PW = $clog2(RES_DEPTH);
    localparam int CW = $clog2(RES_DEPTH + 1);
    localparam logic [CW-1:0] ROOM2_MAX = CW'(RES_DEPTH - 2);

    result_t        slots_reg [RES_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [1:0]     n_push;
    logic           do_pop;
    logic [PW-1:0]  wr_ptr_1;

    assign n_push    = push_en ? push.count : 2'd0;
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign head      = slots_reg[rd_ptr_reg];
    assign room2     = (count_reg <= ROOM2_MAX);
    assign wr_ptr_1  = wr_ptr_reg + PW'(1);

    assign wr_ptr_next = wr_ptr_reg + PW'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PW'(do_pop);
    assign count_next  = count_reg + CW'(n_push) - CW'(do_pop);

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            slots_reg[wr_ptr_reg] <= push.res0;
        end
        if (n_push == 2'd2)
        begin
            slots_reg[wr_ptr_1] <= push.res1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/beacon_remote_id_ie_extractor.sv =====
`timescale 1ns / 1ps
// Beacon remote ID element extractor: top level with input register, config
// registers, element walker and result queue. Depends on bri_pkg.
// A frame byte passes the input register and then the result queue on its way
// to the output. Throughput: one byte per cycle while the queue has room for
// two results; a byte that yields two results (message byte plus end report)
// is absorbed by the four-entry result queue. Reset (rst_n low, async) empties
// the queue and input register and puts the walker in header skip; no clearing pass.
module beacon_remote_id_ie_extractor
    import bri_pkg::*;
#(
    parameter int HEADER_BYTES    = HEADER_BYTES_DEF,
    parameter int MESSAGE_BYTES   = MESSAGE_BYTES_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // Frame byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], frame_length[19:8], zero[23:20]
    input  logic        s_tuser,   // first_byte
    input  logic        s_tlast,   // last_byte
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_out[7:0], byte_index[12:8],
                                   // message_number[20:13], found_any[21], zero[23:22]
    output logic        m_tuser,   // kind
    output logic        m_tlast    // message_end
);

    // Configuration registers
    logic [7:0]  vendor_tag_reg;
    logic [23:0] oui_value_reg;
    logic [7:0]  oui_type_reg;
    logic [7:0]  min_payload_reg;
    cfg_t        cfg;

    // Input register stage
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    in_item_t    in_item_next;

    logic        advance;
    logic        s_accept;
    res_pair_t   results;
    result_t     head;
    logic        not_empty;
    logic        room2;

    assign cfg.vendor_tag      = vendor_tag_reg;
    assign cfg.oui_value       = oui_value_reg;
    assign cfg.oui_type_value  = oui_type_reg;
    assign cfg.min_payload_len = min_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vendor_tag_reg  <= VENDOR_TAG_RST;
            oui_value_reg   <= OUI_VALUE_RST;
            oui_type_reg    <= OUI_TYPE_RST;
            min_payload_reg <= MIN_PAYLOAD_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VENDOR_TAG:  vendor_tag_reg  <= cfg_data[7:0];
                CFG_OUI_VALUE:   oui_value_reg   <= cfg_data;
                CFG_OUI_TYPE:    oui_type_reg    <= cfg_data[7:0];
                CFG_MIN_PAYLOAD: min_payload_reg <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance the walker when a byte is held and the queue has room for two
    assign advance  = in_valid_reg && room2;
    // Take a new transaction when no byte is held or the held byte leaves in this cycle
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign in_item_next.data_byte    = s_tdata[7:0];
    assign in_item_next.first_byte   = s_tuser;
    assign in_item_next.frame_length = s_tdata[19:8];
    assign in_item_next.last_byte    = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_item_reg <= in_item_next;
        end
    end

    bri_walker #(
        .HEADER_BYTES    (HEADER_BYTES),
        .MESSAGE_BYTES   (MESSAGE_BYTES),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg),
        .results (results)
    );

    bri_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (results),
        .pop       (m_tready),
        .head      (head),
        .not_empty (not_empty),
        .room2     (room2)
    );

    // Drive the result transaction straight from the queue head
    assign m_tvalid = not_empty;
    assign m_tuser  = head.kind;
    assign m_tlast  = head.message_end;
    assign m_tdata  = {2'b00, head.found_any, head.message_number,
                       head.byte_index, head.data_out};

endmodule
